/* rtl/tcd_pkg.sv */
// ----------------------------------------------------------------------------
// tcd_pkg
// Shared types and constants for the translated column texture drawer.
// ----------------------------------------------------------------------------
package tcd_pkg;

  localparam int SCREEN_WIDTH_DEF    = 320;
  localparam int TOP_MARGIN_ROWS_DEF = 40;
  localparam int TEXEL_DEPTH_DEF     = 256;

  localparam int OFS_W   = 17;
  localparam int COORD_W = 32;
  localparam int PAL_W   = 32;
  localparam int BYTE_W  = 8;

  typedef logic [2:0] opcode_t;

  localparam opcode_t OP_REMAP_WR = 3'd0;
  localparam opcode_t OP_LIGHT_WR = 3'd1;
  localparam opcode_t OP_PAL_WR   = 3'd2;
  localparam opcode_t OP_TEXEL_WR = 3'd3;
  localparam opcode_t OP_START    = 3'd4;
  localparam opcode_t OP_STEP     = 3'd5;

  typedef logic [1:0] reg_index_t;

  localparam reg_index_t REG_WINDOW_X   = 2'd0;
  localparam reg_index_t REG_WINDOW_Y   = 2'd1;
  localparam reg_index_t REG_CENTER_Y   = 2'd2;
  localparam reg_index_t REG_LOW_DETAIL = 2'd3;

  localparam logic [7:0] CENTER_Y_RESET = 8'd84;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RD_REMAP,
    ST_RD_LIGHT,
    ST_RD_PAL,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic tex_en;
    logic remap_en;
    logic light_en;
    logic pal_en;
  } rd_ctl_t;

  typedef struct packed {
    logic               en;
    opcode_t            op;
    logic [BYTE_W-1:0]  idx;
    logic [PAL_W-1:0]   val;
  } tbl_wr_t;

endpackage

/* rtl/tcd_tables.sv */
// ----------------------------------------------------------------------------
// tcd_tables
// Byte memory with texel, translation and colormap regions, plus a palette
// memory. Each read is registered; each lookup after the texel read addresses the
// next region from the previous read data.
// ----------------------------------------------------------------------------
module tcd_tables
  import tcd_pkg::*;
#(
  parameter int TEXEL_DEPTH = TEXEL_DEPTH_DEF
) (
  input  logic              clk,
  input  tbl_wr_t           wr,
  input  rd_ctl_t           rd,
  input  logic [BYTE_W-1:0] tex_byte,
  output logic [PAL_W-1:0]  pal_data
);

  localparam int MOD_STEPS = 255 / TEXEL_DEPTH;
  localparam logic [10:0] DEPTH_L = 11'(TEXEL_DEPTH);
  localparam int BYTE_DEPTH  = 768;
  localparam int BYTE_ADDR_W = 10;

  localparam logic [1:0] RGN_REMAP = 2'd0;
  localparam logic [1:0] RGN_LIGHT = 2'd1;
  localparam logic [1:0] RGN_TEXEL = 2'd2;

  logic [BYTE_W-1:0] byte_mem [BYTE_DEPTH];
  logic [PAL_W-1:0]  pal_mem  [256];

  logic [BYTE_W-1:0]      byte_q;
  logic [BYTE_ADDR_W-1:0] wr_addr;
  logic                   wr_byte;
  logic [BYTE_ADDR_W-1:0] rd_addr;

  function automatic logic [BYTE_W-1:0] tex_reduce(input logic [BYTE_W-1:0] b);
    logic [10:0] v;
    v = {3'b000, b};
    for (int i = 0; i < MOD_STEPS; i++) begin
      if (v >= DEPTH_L) begin
        v = v - DEPTH_L;
      end
    end
    return v[BYTE_W-1:0];
  endfunction

  always_comb begin
    wr_byte = 1'b0;
    wr_addr = {RGN_REMAP, wr.idx};
    case (wr.op)
      OP_REMAP_WR: begin
        wr_byte = wr.en;
        wr_addr = {RGN_REMAP, wr.idx};
      end
      OP_LIGHT_WR: begin
        wr_byte = wr.en;
        wr_addr = {RGN_LIGHT, wr.idx};
      end
      OP_TEXEL_WR: begin
        wr_byte = wr.en;
        wr_addr = {RGN_TEXEL, tex_reduce(wr.idx)};
      end
      default: ;
    endcase
  end

  always_comb begin
    rd_addr = {RGN_TEXEL, tex_reduce(tex_byte)};
    if (rd.remap_en) begin
      rd_addr = {RGN_REMAP, byte_q};
    end else if (rd.light_en) begin
      rd_addr = {RGN_LIGHT, byte_q};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_byte) begin
      byte_mem[wr_addr] <= wr.val[BYTE_W-1:0];
    end
    if (wr.en && wr.op == OP_PAL_WR) begin
      pal_mem[wr.idx] <= wr.val;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.tex_en || rd.remap_en || rd.light_en) begin
      byte_q <= byte_mem[rd_addr];
    end
    if (rd.pal_en) begin
      pal_data <= pal_mem[byte_q];
    end
  end

endmodule

/* rtl/tcd_seq.sv */
// ----------------------------------------------------------------------------
// tcd_seq
// Column state, configuration registers, item sequencer and result register.
// ----------------------------------------------------------------------------
module tcd_seq
  import tcd_pkg::*;
#(
  parameter int SCREEN_WIDTH    = SCREEN_WIDTH_DEF,
  parameter int TOP_MARGIN_ROWS = TOP_MARGIN_ROWS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  reg_index_t         cfg_index,
  input  logic [8:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  opcode_t            opcode,
  input  logic [BYTE_W-1:0]  entry_index,
  input  logic [PAL_W-1:0]   entry_value,
  input  logic [8:0]         column_x,
  input  logic [7:0]         top_row,
  input  logic [7:0]         bottom_row,
  input  logic [COORD_W-1:0] tex_step,
  input  logic [COORD_W-1:0] tex_mid,
  output tbl_wr_t            tbl_wr,
  output rd_ctl_t            tbl_rd,
  output logic [BYTE_W-1:0]  tex_byte,
  input  logic [PAL_W-1:0]   pal_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [OFS_W-1:0]   pixel_offset,
  output logic [PAL_W-1:0]   pixel_value,
  output logic               wide_write,
  output logic               last_pixel
);

  localparam logic [OFS_W-1:0] MARGIN_OFS   = OFS_W'(TOP_MARGIN_ROWS * SCREEN_WIDTH);
  localparam logic [OFS_W-1:0] ROW_ADV      = OFS_W'(SCREEN_WIDTH);
  localparam logic [OFS_W-1:0] ROW_ADV_WIDE = OFS_W'((SCREEN_WIDTH >> 1) << 1);
  localparam logic [31:0]      WIDTH_L      = 32'(SCREEN_WIDTH);

  state_t state;
  state_t state_next;

  logic [8:0] window_x;
  logic [7:0] window_y;
  logic [7:0] center_y;
  logic       low_detail;

  logic               column_active;
  logic               column_wide;
  logic [COORD_W-1:0] tex_coord;
  logic [COORD_W-1:0] tex_delta;
  logic [OFS_W-1:0]   dest_offset;
  logic [7:0]         rows_left;

  logic [OFS_W-1:0]   row_prod;
  logic [COORD_W-1:0] tex_prod;
  logic [COORD_W-1:0] mid_hold;
  logic [10:0]        x_term;

  logic [OFS_W-1:0] pend_ofs;
  logic             pend_wide;
  logic             pend_last;

  logic               accept;
  logic               start_ok;
  logic               emit;
  logic [8:0]         row_sum;
  logic [31:0]        row_full;
  logic signed [8:0]  row_diff;
  logic [COORD_W-1:0] row_diff_x;
  logic [9:0]         cx_sel;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign start_ok  = (bottom_row >= top_row);
  assign tex_byte  = tex_coord[23:16];

  assign row_sum    = {1'b0, window_y} + {1'b0, top_row};
  assign row_full   = 32'(row_sum) * WIDTH_L;
  assign row_diff   = $signed({1'b0, top_row}) - $signed({1'b0, center_y});
  assign row_diff_x = {{(COORD_W-9){row_diff[8]}}, row_diff};
  assign cx_sel     = low_detail ? {column_x, 1'b0} : {1'b0, column_x};

  assign tbl_wr.en  = accept && (opcode <= OP_TEXEL_WR);
  assign tbl_wr.op  = opcode;
  assign tbl_wr.idx = entry_index;
  assign tbl_wr.val = entry_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    tbl_rd     = '0;
    emit       = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept && opcode == OP_START && start_ok) begin
          state_next = ST_SETUP;
        end else if (accept && opcode == OP_STEP && column_active) begin
          tbl_rd.tex_en = 1'b1;
          state_next    = ST_RD_REMAP;
        end
      end
      ST_SETUP: state_next = ST_IDLE;
      ST_RD_REMAP: begin
        tbl_rd.remap_en = 1'b1;
        state_next      = ST_RD_LIGHT;
      end
      ST_RD_LIGHT: begin
        tbl_rd.light_en = 1'b1;
        state_next      = ST_RD_PAL;
      end
      ST_RD_PAL: begin
        tbl_rd.pal_en = 1'b1;
        state_next    = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid || out_ready) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_x   <= '0;
      window_y   <= '0;
      center_y   <= CENTER_Y_RESET;
      low_detail <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WINDOW_X:   window_x   <= cfg_data;
        REG_WINDOW_Y:   window_y   <= cfg_data[7:0];
        REG_CENTER_Y:   center_y   <= cfg_data[7:0];
        REG_LOW_DETAIL: low_detail <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_active <= 1'b0;
    end else if (accept && opcode == OP_START) begin
      column_active <= start_ok;
    end else if (accept && opcode == OP_STEP && column_active && rows_left == '0) begin
      column_active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && opcode == OP_START && start_ok) begin
      column_wide <= low_detail;
      row_prod    <= row_full[OFS_W-1:0];
      tex_prod    <= row_diff_x * tex_step;
      mid_hold    <= tex_mid;
      tex_delta   <= tex_step;
      x_term      <= {2'b00, window_x} + {1'b0, cx_sel};
      rows_left   <= bottom_row - top_row;
    end else if (state == ST_SETUP) begin
      dest_offset <= row_prod + MARGIN_OFS + OFS_W'(x_term);
      tex_coord   <= mid_hold + tex_prod;
    end else if (accept && opcode == OP_STEP && column_active) begin
      pend_ofs  <= dest_offset;
      pend_wide <= column_wide;
      pend_last <= (rows_left == '0);
      if (rows_left != '0) begin
        rows_left   <= rows_left - 8'd1;
        dest_offset <= dest_offset + (column_wide ? ROW_ADV_WIDE : ROW_ADV);
        tex_coord   <= tex_coord + tex_delta;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pixel_offset <= pend_ofs;
      pixel_value  <= pal_data;
      wide_write   <= pend_wide;
      last_pixel   <= pend_last;
    end
  end

endmodule

/* rtl/translated_column_texture_draw.sv */
// ----------------------------------------------------------------------------
// translated_column_texture_draw
// Textured column drawer with translation, colormap and palette lookups.
// Table writes are registered into the tables; a start item registers a product,
// then a sum. A step item runs four dependent registered memory reads
// (texel, translation, colormap, palette) and a load of the result register once it is free.
// The result register frees the input while a pixel waits to be taken.
// Reset (rst, synchronous) clears the column, the output valid and the config
// registers (center_y to 84); table contents are undefined until written.
// ----------------------------------------------------------------------------
module translated_column_texture_draw
  import tcd_pkg::*;
#(
  parameter int SCREEN_WIDTH    = SCREEN_WIDTH_DEF,
  parameter int TOP_MARGIN_ROWS = TOP_MARGIN_ROWS_DEF,
  parameter int TEXEL_DEPTH     = TEXEL_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [8:0]   cfg_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // entry_index, entry_value, column_x, top_row, bottom_row, tex_step, tex_mid, zero pad
  input  logic [135:0] s_axis_tdata,
  // opcode
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pixel_offset, pixel_value, zero pad
  output logic [55:0]  m_axis_tdata,
  // wide_write
  output logic         m_axis_tuser,
  output logic         m_axis_tlast
);

  tbl_wr_t           tbl_wr;
  rd_ctl_t           tbl_rd;
  logic [BYTE_W-1:0] tex_byte;
  logic [PAL_W-1:0]  pal_data;
  logic [OFS_W-1:0]  pixel_offset;
  logic [PAL_W-1:0]  pixel_value;

  assign m_axis_tdata = {7'b0, pixel_value, pixel_offset};

  tcd_tables #(
    .TEXEL_DEPTH(TEXEL_DEPTH)
  ) u_tables (
    .clk      (clk),
    .wr       (tbl_wr),
    .rd       (tbl_rd),
    .tex_byte (tex_byte),
    .pal_data (pal_data)
  );

  tcd_seq #(
    .SCREEN_WIDTH    (SCREEN_WIDTH),
    .TOP_MARGIN_ROWS (TOP_MARGIN_ROWS)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .opcode       (s_axis_tuser),
    .entry_index  (s_axis_tdata[7:0]),
    .entry_value  (s_axis_tdata[39:8]),
    .column_x     (s_axis_tdata[48:40]),
    .top_row      (s_axis_tdata[56:49]),
    .bottom_row   (s_axis_tdata[64:57]),
    .tex_step     (s_axis_tdata[96:65]),
    .tex_mid      (s_axis_tdata[128:97]),
    .tbl_wr       (tbl_wr),
    .tbl_rd       (tbl_rd),
    .tex_byte     (tex_byte),
    .pal_data     (pal_data),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .pixel_offset (pixel_offset),
    .pixel_value  (pixel_value),
    .wide_write   (m_axis_tuser),
    .last_pixel   (m_axis_tlast)
  );

endmodule
